FILE: rtl/whac_pkg.sv
// ----------------------------------------------------------------------------
// whac_pkg
// Shared types and constants of the weighted histogram accumulator.
// ----------------------------------------------------------------------------
package whac_pkg;

    localparam logic [31:0] RANGE_MIN_RST = 32'h0000_0000;
    localparam logic [30:0] BIN_WIDTH_RST = 31'h0001_0000;
    localparam logic [31:0] INV_WIDTH_RST = 32'h0001_0000;
    localparam logic [8:0]  BIN_COUNT_RST = 9'd256;

    localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;

    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        CFG_RANGE_MIN = 2'd0,
        CFG_BIN_WIDTH = 2'd1,
        CFG_INV_WIDTH = 2'd2,
        CFG_BIN_COUNT = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_READ = 1'b1
    } whac_cmd_t;

    typedef struct packed {
        logic        is_read;
        logic [31:0] weight;
        logic [7:0]  read_index;
        logic        index_valid;
        logic [31:0] centre;
    } whac_job_t;

endpackage

FILE: rtl/whac_front.sv
// ----------------------------------------------------------------------------
// whac_front
// Configuration registers and the two stage binning pipeline: offset from
// the range minimum, reciprocal multiply and bin centre product, then range
// check. Dropped adds go no further; kept words are pushed to the queue.
// ----------------------------------------------------------------------------
module whac_front
    import whac_pkg::*;
#(
    parameter int NUM_BINS = 256,
    parameter int IDXW     = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic            run,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_cmd,
    input  logic [31:0]     in_location,
    input  logic [31:0]     in_weight,
    input  logic [7:0]      in_read_index,
    input  logic            q_full,
    output logic            push,
    output logic [IDXW-1:0] push_bin,
    output whac_job_t       push_job
);

    logic [31:0] range_min_reg;
    logic [30:0] bin_width_reg;
    logic [31:0] inv_width_reg;
    logic [8:0]  bin_count_reg;

    logic        a_valid_reg;
    logic        a_cmd_reg;
    logic [32:0] a_diff_reg;
    logic [31:0] a_weight_reg;
    logic [7:0]  a_idx_reg;

    logic        b_valid_reg;
    logic        b_cmd_reg;
    logic        b_neg_reg;
    logic [31:0] b_bin_reg;
    logic [39:0] b_half_reg;
    logic [31:0] b_weight_reg;
    logic [7:0]  b_idx_reg;

    logic [8:0]  used;
    logic        inv_zero;
    logic        add_hit;
    logic        read_ok;
    logic        b_keep;
    logic        adv;
    logic        accept;
    logic [63:0] bin_prod;
    logic [39:0] half_prod;
    logic [31:0] centre;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= RANGE_MIN_RST;
            bin_width_reg <= BIN_WIDTH_RST;
            inv_width_reg <= INV_WIDTH_RST;
            bin_count_reg <= BIN_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RANGE_MIN: range_min_reg <= cfg_data;
                CFG_BIN_WIDTH: bin_width_reg <= cfg_data[30:0];
                CFG_INV_WIDTH: inv_width_reg <= cfg_data;
                CFG_BIN_COUNT: bin_count_reg <= cfg_data[8:0];
            endcase
        end
    end

    always_comb
    begin
        used      = (32'(bin_count_reg) > 32'(NUM_BINS)) ? 9'(NUM_BINS) : bin_count_reg;
        inv_zero  = (inv_width_reg == 32'd0);
        // a zero reciprocal gives bin 0, still subject to the bins in use
        add_hit   = (inv_zero || !b_neg_reg) && (b_bin_reg < {23'd0, used});
        read_ok   = ({1'b0, b_idx_reg} < used);
        b_keep    = b_cmd_reg || add_hit;
        adv       = !b_valid_reg || !b_keep || !q_full;
        in_ready  = run && adv;
        accept    = in_valid && in_ready;
        bin_prod  = 64'(a_diff_reg[31:0]) * 64'(inv_width_reg);
        half_prod = 40'(bin_width_reg) * 40'({a_idx_reg, 1'b1});
        centre    = range_min_reg + b_half_reg[32:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_cmd_reg    <= in_cmd;
            a_diff_reg   <= {in_location[31], in_location} - {range_min_reg[31], range_min_reg};
            a_weight_reg <= in_weight;
            a_idx_reg    <= in_read_index;
        end
        if (adv && a_valid_reg)
        begin
            b_cmd_reg    <= a_cmd_reg;
            b_neg_reg    <= a_diff_reg[32];
            b_bin_reg    <= bin_prod[63:32];
            b_half_reg   <= half_prod;
            b_weight_reg <= a_weight_reg;
            b_idx_reg    <= a_idx_reg;
        end
    end

    always_comb
    begin
        push                 = b_valid_reg && b_keep && !q_full;
        push_job.is_read     = b_cmd_reg;
        push_job.weight      = b_weight_reg;
        push_job.read_index  = b_idx_reg;
        push_job.index_valid = read_ok;
        push_job.centre      = read_ok ? centre : 32'd0;
        if (b_cmd_reg)
            push_bin = IDXW'(b_idx_reg);
        else if (inv_zero)
            push_bin = '0;
        else
            push_bin = IDXW'(b_bin_reg);
    end

endmodule

FILE: rtl/whac_fifo.sv
// ----------------------------------------------------------------------------
// whac_fifo
// Short queue between the binning front end and the bin update engine.
// ----------------------------------------------------------------------------
module whac_fifo
    import whac_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    logic [W-1:0]  mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/whac_back.sv
// ----------------------------------------------------------------------------
// whac_back
// Bin store and update engine: clearing pass after reset, then one
// read-modify-write or one bin report per queued word, one word at a time.
// ----------------------------------------------------------------------------
module whac_back
    import whac_pkg::*;
#(
    parameter int NUM_BINS = 256,
    parameter int IDXW     = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    output logic            clear_done,
    input  logic            q_empty,
    input  logic [IDXW-1:0] q_bin,
    input  whac_job_t       q_job,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_bin_number,
    output logic            out_index_valid,
    output logic [31:0]     out_hit_count,
    output logic [47:0]     out_weight_total,
    output logic [31:0]     out_bin_centre
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t          state_reg;
    logic [IDXW-1:0] clr_addr_reg;
    logic [IDXW-1:0] addr_reg;
    whac_job_t       job_reg;
    logic            out_valid_reg;
    logic [7:0]      out_bin_reg;
    logic            out_idx_ok_reg;
    logic [31:0]     out_count_reg;
    logic [47:0]     out_sum_reg;
    logic [31:0]     out_centre_reg;

    logic [31:0]     count_mem [NUM_BINS];
    logic [47:0]     sum_mem   [NUM_BINS];
    logic [31:0]     rd_count_reg;
    logic [47:0]     rd_sum_reg;

    logic            out_free;
    logic            mem_we;
    logic [IDXW-1:0] mem_addr;
    logic [31:0]     count_next;
    logic [47:0]     sum_next;
    logic [48:0]     sum_wide;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        q_pop    = (state_reg == ST_IDLE) && !q_empty && (!q_job.is_read || out_free);
        sum_wide = {rd_sum_reg[47], rd_sum_reg} + {{17{job_reg.weight[31]}}, job_reg.weight};
        if (state_reg == ST_CLEAR)
        begin
            count_next = 32'd0;
            sum_next   = 48'd0;
        end
        else
        begin
            count_next = (rd_count_reg == 32'hFFFF_FFFF) ? rd_count_reg : rd_count_reg + 32'd1;
            if (sum_wide[48] != sum_wide[47])
                sum_next = sum_wide[48] ? SUM_MIN : SUM_MAX;
            else
                sum_next = sum_wide[47:0];
        end
        mem_we   = (state_reg == ST_CLEAR) || ((state_reg == ST_UPDATE) && !job_reg.is_read);
        mem_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_addr] <= count_next;
            sum_mem[mem_addr]   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_count_reg <= count_mem[q_bin];
            rd_sum_reg   <= sum_mem[q_bin];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == IDXW'(NUM_BINS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        job_reg   <= q_job;
                        addr_reg  <= q_bin;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (job_reg.is_read)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_bin_reg    <= job_reg.read_index;
                        out_idx_ok_reg <= job_reg.index_valid;
                        out_count_reg  <= job_reg.index_valid ? rd_count_reg : 32'd0;
                        out_sum_reg    <= job_reg.index_valid ? rd_sum_reg : 48'd0;
                        out_centre_reg <= job_reg.centre;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign clear_done       = (state_reg != ST_CLEAR);
    assign out_valid        = out_valid_reg;
    assign out_bin_number   = out_bin_reg;
    assign out_index_valid  = out_idx_ok_reg;
    assign out_hit_count    = out_count_reg;
    assign out_weight_total = out_sum_reg;
    assign out_bin_centre   = out_centre_reg;

endmodule

FILE: rtl/weighted_histogram_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator
// Uniform-bin histogram with saturating hit count and weight sum per bin.
//
// channel  dir  handshake                 contents
// s_axis   in   s_axis_tvalid/tready      add sample or bin read request
// m_axis   out  m_axis_tvalid/tready      one bin report per read
// cfg      in   cfg_valid/cfg_ready       register index and write data
//
// Front end: one word per cycle while the queue has room, binning in stages a
// and b, drops out-of-range adds. Bin engine: one kept word at a time (single
// port read-modify-write on the bin store); a read's report is registered at m_axis.
// After reset a clearing pass over all NUM_BINS bins runs with s_axis_tready low.
// A stalled m_axis holds the next read at the head of the 4-word queue; words
// behind it queue up until the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module weighted_histogram_accumulator
    import whac_pkg::*;
#(
    parameter int NUM_BINS = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // location[31:0], weight[63:32], read_index[71:64]
    input  logic         s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // bin_number[7:0], hit_count[39:8],
                                         // weight_total[87:40], bin_centre[119:88]
    output logic         m_axis_tuser,   // index_valid
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IDXW = $clog2(NUM_BINS);
    localparam int QW   = $bits(whac_job_t) + IDXW;

    logic            run;
    logic            push;
    logic [IDXW-1:0] push_bin;
    whac_job_t       push_job;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic [QW-1:0]   q_data;
    logic [IDXW-1:0] q_bin;
    whac_job_t       q_job;
    logic [7:0]      out_bin_number;
    logic [31:0]     out_hit_count;
    logic [47:0]     out_weight_total;
    logic [31:0]     out_bin_centre;

    assign cfg_ready = 1'b1;

    whac_front #(
        .NUM_BINS (NUM_BINS),
        .IDXW     (IDXW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .run           (run),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_cmd        (s_axis_tuser),
        .in_location   (s_axis_tdata[31:0]),
        .in_weight     (s_axis_tdata[63:32]),
        .in_read_index (s_axis_tdata[71:64]),
        .q_full        (q_full),
        .push          (push),
        .push_bin      (push_bin),
        .push_job      (push_job)
    );

    whac_fifo #(
        .W (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_bin, push_job}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    assign q_bin = q_data[QW-1 -: IDXW];
    assign q_job = whac_job_t'(q_data[$bits(whac_job_t)-1:0]);

    whac_back #(
        .NUM_BINS (NUM_BINS),
        .IDXW     (IDXW)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .clear_done       (run),
        .q_empty          (q_empty),
        .q_bin            (q_bin),
        .q_job            (q_job),
        .q_pop            (q_pop),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_bin_number   (out_bin_number),
        .out_index_valid  (m_axis_tuser),
        .out_hit_count    (out_hit_count),
        .out_weight_total (out_weight_total),
        .out_bin_centre   (out_bin_centre)
    );

    assign m_axis_tdata = {out_bin_centre, out_weight_total, out_hit_count, out_bin_number};

endmodule

FILE: rtl/whac_checker.sv
// ----------------------------------------------------------------------------
// whac_checker
// Port-level checks of the histogram accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module whac_checker
    import whac_pkg::*;
#(
    parameter int NUM_BINS = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [119:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [8:0] bin_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bin_count_reg <= BIN_COUNT_RST;
        else if (cfg_valid && cfg_ready && (cfg_idx_t'(cfg_index) == CFG_BIN_COUNT))
            bin_count_reg <= cfg_data[8:0];
    end

    // no words taken while reset is asserted
    a_reset_blocks: assert property (@(posedge clk) !rst_n |-> !s_axis_tready)
        else $error("input ready during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[119:8] == 112'd0)
        else $error("invalid bin report carries data");

    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            ({1'b0, m_axis_tdata[7:0]} < bin_count_reg) &&
            (32'(m_axis_tdata[7:0]) < 32'(NUM_BINS)))
        else $error("bin reported valid outside bins in use");

    a_invalid_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            ({1'b0, m_axis_tdata[7:0]} >= bin_count_reg) ||
            (32'(m_axis_tdata[7:0]) >= 32'(NUM_BINS)))
        else $error("bin in use reported invalid");

endmodule

bind weighted_histogram_accumulator whac_checker #(
    .NUM_BINS (NUM_BINS)
) u_whac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);
